// File: design/mnpd_pkg.sv
// Shared types and constants for the M/N pin debouncer.
package mnpd_pkg;

   localparam int NUM_PORTS    = 4;
   localparam int PORT_PINS    = 8;
   localparam int THRESH_REG_W = 5;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 8;

   localparam logic OP_POLL = 1'b0;
   localparam logic OP_INIT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFER   = 3'd5;

   localparam logic [THRESH_REG_W-1:0] TICKS_RESET  = 5'd4;
   localparam logic [THRESH_REG_W-1:0] DIFFER_RESET = 5'd3;

   typedef struct packed {
      logic       opcode;
      logic [7:0] pins_a;
      logic [7:0] pins_b;
      logic [7:0] pins_c;
      logic [7:0] pins_d;
   } req_type;

   typedef struct packed {
      logic [7:0] level_a;
      logic [7:0] level_b;
      logic [7:0] level_c;
      logic [7:0] level_d;
      logic [7:0] changed_a;
      logic [7:0] changed_b;
      logic [7:0] changed_c;
      logic [7:0] changed_d;
      logic       any_change;
   } rsp_type;

   typedef struct packed {
      logic [PORT_PINS-1:0] level;
      logic [PORT_PINS-1:0] changed;
   } lane_result_type;

endpackage

// File: design/mn_pin_debouncer.sv
// Top level of the M/N pin debouncer: registers, four port lanes and the merge stage.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_data  (opcode, pins_a..pins_d)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data  (levels, change flags, any_change)
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One request per cycle while req_stall is low; its response is registered (output or skid register).
// All 32 pins are updated in parallel by four 8-pin lanes in the accepting cycle.
// A two-entry output stage (output plus skid register) lets requests flow while rsp stalls;
// req_stall rises only once both entries are full.
// Synchronous reset clears levels, counters, enables and output valid flags, and loads the threshold defaults.
module mn_pin_debouncer #(
   parameter int TICK_BITS   = 4,
   parameter int DIFFER_BITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mnpd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mnpd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mnpd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mnpd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int TICK_W   = (TICK_BITS > mnpd_pkg::THRESH_REG_W) ?
                             TICK_BITS + 1 : mnpd_pkg::THRESH_REG_W + 1;
   localparam int DIFFER_W = (DIFFER_BITS > mnpd_pkg::THRESH_REG_W) ?
                             DIFFER_BITS + 1 : mnpd_pkg::THRESH_REG_W + 1;

   logic [mnpd_pkg::PORT_PINS-1:0]    enable_ff [mnpd_pkg::NUM_PORTS];
   logic [mnpd_pkg::THRESH_REG_W-1:0] ticks_ff;
   logic [mnpd_pkg::THRESH_REG_W-1:0] differ_ff;

   logic [TICK_W-1:0]      tick_t;
   logic [TICK_W-1:0]      tick_max;
   logic [DIFFER_W-1:0]    differ_t;
   logic [DIFFER_W-1:0]    differ_max;
   logic [TICK_BITS-1:0]   tick_th;
   logic [DIFFER_BITS-1:0] diff_th;

   logic                              accept;
   logic                              full;
   logic [mnpd_pkg::PORT_PINS-1:0]    pins [mnpd_pkg::NUM_PORTS];
   mnpd_pkg::lane_result_type [mnpd_pkg::NUM_PORTS-1:0] lane_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < mnpd_pkg::NUM_PORTS; k++) begin
            enable_ff[k] <= '0;
         end
         ticks_ff  <= mnpd_pkg::TICKS_RESET;
         differ_ff <= mnpd_pkg::DIFFER_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mnpd_pkg::CSR_ENABLE_A: enable_ff[0] <= csr_data;
            mnpd_pkg::CSR_ENABLE_B: enable_ff[1] <= csr_data;
            mnpd_pkg::CSR_ENABLE_C: enable_ff[2] <= csr_data;
            mnpd_pkg::CSR_ENABLE_D: enable_ff[3] <= csr_data;
            mnpd_pkg::CSR_TICKS:    ticks_ff  <= csr_data[mnpd_pkg::THRESH_REG_W-1:0];
            mnpd_pkg::CSR_DIFFER:   differ_ff <= csr_data[mnpd_pkg::THRESH_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // threshold is reg-1, zero treated as one, saturated at the counter's top value
   always_comb begin
      tick_t     = (ticks_ff == '0) ? '0 : (TICK_W'(ticks_ff) - TICK_W'(1));
      tick_max   = TICK_W'((1 << TICK_BITS) - 1);
      differ_t   = (differ_ff == '0) ? '0 : (DIFFER_W'(differ_ff) - DIFFER_W'(1));
      differ_max = DIFFER_W'((1 << DIFFER_BITS) - 1);
      tick_th    = (tick_t > tick_max) ? tick_max[TICK_BITS-1:0] : tick_t[TICK_BITS-1:0];
      diff_th    = (differ_t > differ_max) ? differ_max[DIFFER_BITS-1:0]
                                           : differ_t[DIFFER_BITS-1:0];
   end

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   assign pins[0] = req_data.pins_a;
   assign pins[1] = req_data.pins_b;
   assign pins[2] = req_data.pins_c;
   assign pins[3] = req_data.pins_d;

   for (genvar k = 0; k < mnpd_pkg::NUM_PORTS; k++) begin : g_lane
      mnpd_lane #(
         .TICK_BITS   (TICK_BITS),
         .DIFFER_BITS (DIFFER_BITS)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .go      (accept),
         .init    (req_data.opcode == mnpd_pkg::OP_INIT),
         .enable  (enable_ff[k]),
         .pins    (pins[k]),
         .tick_th (tick_th),
         .diff_th (diff_th),
         .result  (lane_res[k])
      );
   end

   mnpd_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .lanes     (lane_res),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/mnpd_lane.sv
// One port lane: per-pin tick and differ counters and the debounced levels.
module mnpd_lane #(
   parameter int TICK_BITS   = 4,
   parameter int DIFFER_BITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic                                init,
   input  logic [mnpd_pkg::PORT_PINS-1:0]      enable,
   input  logic [mnpd_pkg::PORT_PINS-1:0]      pins,
   input  logic [TICK_BITS-1:0]                tick_th,
   input  logic [DIFFER_BITS-1:0]              diff_th,
   output mnpd_pkg::lane_result_type           result
);

   logic [mnpd_pkg::PORT_PINS-1:0] level_ff;
   logic [mnpd_pkg::PORT_PINS-1:0] level_in;
   logic [TICK_BITS-1:0]           tick_ff   [mnpd_pkg::PORT_PINS];
   logic [TICK_BITS-1:0]           tick_in   [mnpd_pkg::PORT_PINS];
   logic [DIFFER_BITS-1:0]         differ_ff [mnpd_pkg::PORT_PINS];
   logic [DIFFER_BITS-1:0]         differ_in [mnpd_pkg::PORT_PINS];

   always_comb begin
      for (int i = 0; i < mnpd_pkg::PORT_PINS; i++) begin
         level_in[i]  = level_ff[i];
         tick_in[i]   = tick_ff[i];
         differ_in[i] = differ_ff[i];
         if (init) begin
            level_in[i]  = enable[i] & pins[i];
            tick_in[i]   = '0;
            differ_in[i] = '0;
         end else if (enable[i]) begin
            if (tick_ff[i] < tick_th) begin
               tick_in[i] = tick_ff[i] + TICK_BITS'(1);
            end else if (pins[i] == level_ff[i]) begin
               differ_in[i] = '0;
            end else if (differ_ff[i] >= diff_th) begin
               tick_in[i]   = '0;
               differ_in[i] = '0;
               level_in[i]  = ~level_ff[i];
            end else begin
               differ_in[i] = differ_ff[i] + DIFFER_BITS'(1);
            end
         end
      end
   end

   assign result.level   = level_in;
   assign result.changed = init ? '0 : (level_in ^ level_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         for (int i = 0; i < mnpd_pkg::PORT_PINS; i++) begin
            tick_ff[i]   <= '0;
            differ_ff[i] <= '0;
         end
      end else if (go) begin
         level_ff <= level_in;
         for (int i = 0; i < mnpd_pkg::PORT_PINS; i++) begin
            tick_ff[i]   <= tick_in[i];
            differ_ff[i] <= differ_in[i];
         end
      end
   end

endmodule

// File: design/mnpd_merge.sv
// Merge stage: gathers lane results, forms the any-change flag, output and skid registers.
module mnpd_merge (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   push,
   input  mnpd_pkg::lane_result_type [mnpd_pkg::NUM_PORTS-1:0]    lanes,
   output logic                                                   full,
   output logic                                                   rsp_valid,
   input  logic                                                   rsp_stall,
   output mnpd_pkg::rsp_type                                      rsp_data
);

   mnpd_pkg::rsp_type merged;
   mnpd_pkg::rsp_type main_ff;
   mnpd_pkg::rsp_type skid_ff;
   logic              main_valid_ff;
   logic              skid_valid_ff;
   logic              pop;

   always_comb begin
      merged.level_a    = lanes[0].level;
      merged.level_b    = lanes[1].level;
      merged.level_c    = lanes[2].level;
      merged.level_d    = lanes[3].level;
      merged.changed_a  = lanes[0].changed;
      merged.changed_b  = lanes[1].changed;
      merged.changed_c  = lanes[2].changed;
      merged.changed_d  = lanes[3].changed;
      merged.any_change = |{lanes[0].changed, lanes[1].changed,
                            lanes[2].changed, lanes[3].changed};
   end

   assign pop       = main_valid_ff & ~rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else if (push) begin
            main_ff <= merged;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_ff <= merged;
         end else begin
            main_ff <= merged;
         end
      end
   end

`ifndef SYNTH
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid register holds a request while the output register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("request accepted while skid register is full");

   a_any_change_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.any_change ==
         (|{rsp_data.changed_a, rsp_data.changed_b,
            rsp_data.changed_c, rsp_data.changed_d})))
      else $error("any_change disagrees with per-port change flags");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff)
      else $error("skid register not drained after output taken");
`endif

endmodule

// File: test/tb_mn_pin_debouncer.sv
// Self-checking testbench for the M/N pin debouncer: random handshakes, CSR phases, own predictor.
module tb_mn_pin_debouncer;

   localparam int TICK_W   = 4;
   localparam int DIFFER_W = 4;
   localparam int PHASES   = 12;
   localparam int PHASE_REQUESTS = 90;
   localparam logic [mnpd_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [mnpd_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mnpd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mnpd_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mnpd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mnpd_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   logic [7:0] en_mask [4];
   logic [4:0] ticks_reg;
   logic [4:0] differ_reg;
   logic [7:0] level_q [4];
   logic [3:0] tick_cnt [32];
   logic [3:0] diff_cnt [32];

   mnpd_pkg::req_type pending_requests [$];
   mnpd_pkg::rsp_type due_responses [$];
   mnpd_pkg::rsp_type want_rsp;
   logic [7:0] settled_pins [4];

   int errors = 0;
   int requests_queued = 0;
   int requests_taken = 0;
   int responses_seen = 0;
   int toggle_responses = 0;
   int init_requests = 0;
   int settings_used = 0;
   bit req_taken = 1'b0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;

   mn_pin_debouncer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   function automatic int limit_of(logic [4:0] r, int w);
      int t;
      t = (r == 5'd0) ? 0 : int'(r) - 1;
      return (t > (1 << w) - 1) ? (1 << w) - 1 : t;
   endfunction

   function automatic mnpd_pkg::rsp_type debounce_step(mnpd_pkg::req_type r);
      logic [7:0] pins [4];
      logic [7:0] chg [4];
      logic [7:0] prev;
      logic [7:0] lvl;
      int tl;
      int dl;
      int idx;
      mnpd_pkg::rsp_type o;
      pins = '{r.pins_a, r.pins_b, r.pins_c, r.pins_d};
      chg = '{default: 8'h00};
      if (r.opcode == mnpd_pkg::OP_INIT) begin
         for (int k = 0; k < 4; k++) level_q[k] = en_mask[k] & pins[k];
         for (int i = 0; i < 32; i++) begin
            tick_cnt[i] = '0;
            diff_cnt[i] = '0;
         end
      end else begin
         tl = limit_of(ticks_reg, TICK_W);
         dl = limit_of(differ_reg, DIFFER_W);
         for (int k = 0; k < 4; k++) begin
            prev = level_q[k];
            lvl = prev;
            for (int p = 0; p < 8; p++) begin
               idx = k * 8 + p;
               if (en_mask[k][p]) begin
                  if (tick_cnt[idx] < tl) begin
                     tick_cnt[idx] = tick_cnt[idx] + 4'd1;
                  end else if (prev[p] == pins[k][p]) begin
                     diff_cnt[idx] = '0;
                  end else if (diff_cnt[idx] >= dl) begin
                     tick_cnt[idx] = '0;
                     diff_cnt[idx] = '0;
                     lvl[p] = ~lvl[p];
                  end else begin
                     diff_cnt[idx] = diff_cnt[idx] + 4'd1;
                  end
               end
            end
            level_q[k] = lvl;
            chg[k] = lvl ^ prev;
         end
      end
      o.level_a    = level_q[0];
      o.level_b    = level_q[1];
      o.level_c    = level_q[2];
      o.level_d    = level_q[3];
      o.changed_a  = chg[0];
      o.changed_b  = chg[1];
      o.changed_c  = chg[2];
      o.changed_d  = chg[3];
      o.any_change = |{chg[0], chg[1], chg[2], chg[3]};
      return o;
   endfunction

   function automatic logic [4:0] pick_threshold(int sel);
      case (sel % 7)
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd16;
         3: return 5'd31;
         4: return 5'd17;
         default: return 5'($urandom_range(6, 2));
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch on %s at %0t: got %h, want %h", what, $time, got, want);
   endtask

   task automatic queue_request(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                logic [7:0] d);
      mnpd_pkg::req_type r;
      r.opcode = op;
      r.pins_a = a;
      r.pins_b = b;
      r.pins_c = c;
      r.pins_d = d;
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   task automatic csr_write(logic [mnpd_pkg::CSR_IDX_W-1:0] idx,
                            logic [mnpd_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mnpd_pkg::CSR_ENABLE_A: en_mask[0] = val;
         mnpd_pkg::CSR_ENABLE_B: en_mask[1] = val;
         mnpd_pkg::CSR_ENABLE_C: en_mask[2] = val;
         mnpd_pkg::CSR_ENABLE_D: en_mask[3] = val;
         mnpd_pkg::CSR_TICKS:    ticks_reg  = val[4:0];
         mnpd_pkg::CSR_DIFFER:   differ_reg = val[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (requests_taken != requests_queued || due_responses.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
      settings_used++;
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = 64;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 13);
      end
   end

   // monitor
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            requests_taken++;
            if (req_data.opcode == mnpd_pkg::OP_INIT) init_requests++;
            due_responses.push_back(debounce_step(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               report_mismatch("response with none due", 64'(rsp_data), '0);
            end else begin
               want_rsp = due_responses.pop_front();
               responses_seen++;
               if (rsp_data.any_change) toggle_responses++;
               if (rsp_data.level_a !== want_rsp.level_a)
                  report_mismatch("level_a", 64'(rsp_data.level_a), 64'(want_rsp.level_a));
               if (rsp_data.level_b !== want_rsp.level_b)
                  report_mismatch("level_b", 64'(rsp_data.level_b), 64'(want_rsp.level_b));
               if (rsp_data.level_c !== want_rsp.level_c)
                  report_mismatch("level_c", 64'(rsp_data.level_c), 64'(want_rsp.level_c));
               if (rsp_data.level_d !== want_rsp.level_d)
                  report_mismatch("level_d", 64'(rsp_data.level_d), 64'(want_rsp.level_d));
               if (rsp_data.changed_a !== want_rsp.changed_a)
                  report_mismatch("changed_a", 64'(rsp_data.changed_a),
                                  64'(want_rsp.changed_a));
               if (rsp_data.changed_b !== want_rsp.changed_b)
                  report_mismatch("changed_b", 64'(rsp_data.changed_b),
                                  64'(want_rsp.changed_b));
               if (rsp_data.changed_c !== want_rsp.changed_c)
                  report_mismatch("changed_c", 64'(rsp_data.changed_c),
                                  64'(want_rsp.changed_c));
               if (rsp_data.changed_d !== want_rsp.changed_d)
                  report_mismatch("changed_d", 64'(rsp_data.changed_d),
                                  64'(want_rsp.changed_d));
               if (rsp_data.any_change !== want_rsp.any_change)
                  report_mismatch("any_change", 64'(rsp_data.any_change),
                                  64'(want_rsp.any_change));
            end
         end
      end
   end

   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int roll;
      logic [7:0] p [4];
      en_mask    = '{default: 8'h00};
      level_q    = '{default: 8'h00};
      tick_cnt   = '{default: 4'h0};
      diff_cnt   = '{default: 4'h0};
      ticks_reg  = mnpd_pkg::TICKS_RESET;
      differ_reg = mnpd_pkg::DIFFER_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: every pin disabled
      queue_request(mnpd_pkg::OP_POLL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_request(mnpd_pkg::OP_INIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_request(mnpd_pkg::OP_POLL, 8'h00, 8'h00, 8'h00, 8'h00);
      drain();

      // zero thresholds: every differing sample toggles
      csr_write(mnpd_pkg::CSR_ENABLE_A, 8'hFF);
      csr_write(mnpd_pkg::CSR_ENABLE_B, 8'hFF);
      csr_write(mnpd_pkg::CSR_ENABLE_C, 8'hFF);
      csr_write(mnpd_pkg::CSR_ENABLE_D, 8'hFF);
      csr_write(mnpd_pkg::CSR_TICKS, 8'h00);
      csr_write(mnpd_pkg::CSR_DIFFER, 8'h00);
      queue_request(mnpd_pkg::OP_POLL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_request(mnpd_pkg::OP_POLL, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(mnpd_pkg::OP_POLL, 8'hA5, 8'h5A, 8'h0F, 8'hF0);
      queue_request(mnpd_pkg::OP_POLL, 8'h5A, 8'hA5, 8'hF0, 8'h0F);
      queue_request(mnpd_pkg::OP_INIT, 8'h0F, 8'hF0, 8'h33, 8'hCC);
      queue_request(mnpd_pkg::OP_POLL, 8'h00, 8'h00, 8'h00, 8'h00);
      drain();

      // partial masks, upper data bits set on the threshold registers
      csr_write(mnpd_pkg::CSR_ENABLE_A, 8'hA5);
      csr_write(mnpd_pkg::CSR_ENABLE_B, 8'h5A);
      csr_write(mnpd_pkg::CSR_ENABLE_C, 8'h00);
      csr_write(mnpd_pkg::CSR_TICKS, 8'hE2);
      csr_write(mnpd_pkg::CSR_DIFFER, 8'h42);
      repeat (5) queue_request(mnpd_pkg::OP_POLL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      repeat (4) queue_request(mnpd_pkg::OP_POLL, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_request(mnpd_pkg::OP_INIT, 8'h00, 8'h00, 8'h00, 8'h00);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         for (int k = 0; k < 4; k++) begin
            roll = $urandom_range(9);
            csr_write(mnpd_pkg::CSR_ENABLE_A + 3'(k),
                      (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom));
            settled_pins[k] = 8'($urandom);
         end
         csr_write(mnpd_pkg::CSR_TICKS, {3'($urandom), pick_threshold(ph)});
         csr_write(mnpd_pkg::CSR_DIFFER, {3'($urandom), pick_threshold(ph + 2)});
         if (ph == 4) begin
            csr_write(CSR_SPARE_LO, 8'($urandom));
            csr_write(CSR_SPARE_HI, 8'($urandom));
         end
         steady = (ph == 6);
         if (ph % 3 == 0)
            queue_request(mnpd_pkg::OP_INIT, settled_pins[0], settled_pins[1],
                          settled_pins[2], settled_pins[3]);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            roll = $urandom_range(99);
            for (int k = 0; k < 4; k++) begin
               if ($urandom_range(19) == 0) settled_pins[k] ^= 8'($urandom);
               p[k] = settled_pins[k];
               if ($urandom_range(9) < 4) p[k] ^= 8'($urandom & $urandom & $urandom);
               if (roll >= 90) p[k] = 8'($urandom);
            end
            queue_request((roll < 5) ? mnpd_pkg::OP_INIT : mnpd_pkg::OP_POLL,
                          p[0], p[1], p[2], p[3]);
         end
         if (ph == 2) hold_request = 1'b1;
         drain();
      end
      steady = 1'b0;

      $display("Ran %0d requests (%0d init) over %0d settings; %0d responses, %0d with a toggle",
               requests_taken, init_requests, settings_used, responses_seen, toggle_responses);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
